@@ design/fbd_pkg.sv @@
// ----------------------------------------------------------------------------
// fbd_pkg
// Types and constants shared by the fractional baud divider search and its
// shared divider unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fbd_pkg;

  localparam int DIV_W       = 32;
  localparam int CLOCK_W     = 29;
  localparam int RATE_W      = 27;
  localparam int FIELD_W     = 10;
  // core clock / 100 and rate / 100 after scaling
  localparam int CLK_DIV_W   = 23;
  localparam int RATE_DIV_W  = 21;
  localparam int STEP_W      = 10;
  localparam int FRAC_BITS   = 10;
  localparam int CNT_W       = $clog2(DIV_W);

  localparam logic [STEP_W-1:0]  STEP_MAX       = 10'd1023;
  localparam logic [DIV_W-1:0]   PRESCALE_LIMIT = 32'd1024;
  localparam logic [DIV_W-1:0]   SCALE_DOWN     = 32'd100;
  localparam logic [CLOCK_W-1:0] CLOCK_RESET    = 29'd100000000;

  localparam logic [FIELD_W-1:0] FRAC_DEFAULT     = 10'h3ff;
  localparam logic [FIELD_W-1:0] STEP_DEFAULT     = 10'd1;
  localparam logic [FIELD_W-1:0] PRESCALE_DEFAULT = 10'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_CLK,
    ST_DIV_RATE,
    ST_MUL,
    ST_DIV_STEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ design/fbd_div.sv @@
// ----------------------------------------------------------------------------
// fbd_div
// Restoring radix-2 divider, one quotient bit per cycle. A start pulse loads
// the operands; done pulses for one cycle with the quotient valid.
// ----------------------------------------------------------------------------
`default_nettype none

module fbd_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fbd_pkg::div_req_t req,
  output fbd_pkg::div_rsp_t     rsp
);
  import fbd_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dvs;

  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_sub;
  logic             fits;

  always_comb begin
    rem_sh  = {rem, quo[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    fits    = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= rem_sub[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

@@ design/fractional_baud_divider_search.sv @@
// ----------------------------------------------------------------------------
// fractional_baud_divider_search
// Searches fractional divider steps 1023 down to 1 for the step whose
// quotient clock*step/rate has the smallest 10-bit fraction with a prescale
// below 1024, using one shared iterative divider.
//
//   channel   signals                                  direction
//   cfg       cfg_wr_en, cfg_wr_data (core clock Hz)   in, no wait
//   in        in_valid/in_ready, requested_rate_hz     in
//   out       out_valid/out_ready, divider_step,       out
//             prescale_int, frac_residue, rate_error
//
// Items are taken one at a time: each runs to ST_DONE before the next is
// accepted. Every step multiplies in ST_MUL and then divides in ST_DIV_STEP
// through the shared divider, after two divider passes up front that scale
// clock and rate by 100; a rate under 100 Hz finishes after those passes.
// in_ready is high only while idle and out of reset; a finished result waits
// in the output register while the next item is taken.
// Synchronous reset clears the FSM, output valid and loads the default clock.
// ----------------------------------------------------------------------------
`default_nettype none

module fractional_baud_divider_search (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [28:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [26:0] requested_rate_hz,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [9:0]       divider_step,
  output logic [9:0]       prescale_int,
  output logic [9:0]       frac_residue,
  output logic             rate_error
);
  import fbd_pkg::*;

  state_t state, state_next;

  logic [CLOCK_W-1:0]    core_clock;
  logic [RATE_W-1:0]     rate_hz;
  logic [CLK_DIV_W-1:0]  clk_div;
  logic [RATE_DIV_W-1:0] rate_div;
  logic [STEP_W-1:0]     step_counter;
  logic [FIELD_W-1:0]    best_fraction;
  logic [FIELD_W-1:0]    best_step;
  logic [FIELD_W-1:0]    best_prescale;
  logic                  err;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                   in_fire;
  logic                   out_load;
  logic [DIV_W:0]         prod_full;
  logic [DIV_W-1:0]       whole;
  logic [FRAC_BITS-1:0]   frac;
  logic                   better;

  fbd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_fire = in_valid && in_ready;

  always_comb begin
    prod_full = {{(DIV_W + 1 - CLK_DIV_W){1'b0}}, clk_div}
              * {{(DIV_W + 1 - STEP_W){1'b0}}, step_counter};
    whole     = div_rsp.quotient >> FRAC_BITS;
    frac      = div_rsp.quotient[FRAC_BITS-1:0];
    better    = (whole < PRESCALE_LIMIT) && (FIELD_W'(frac) < best_fraction);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    in_ready         = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(core_clock);
    div_req.divisor  = SCALE_DOWN;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          div_req.start = 1'b1;
          state_next    = ST_DIV_CLK;
        end
      end
      ST_DIV_CLK: begin
        div_req.dividend = DIV_W'(rate_hz);
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          state_next    = ST_DIV_RATE;
        end
      end
      ST_DIV_RATE: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        // divider input register holds the product
        div_req.start    = 1'b1;
        div_req.dividend = prod_full[DIV_W-1:0];
        div_req.divisor  = DIV_W'(rate_div);
        state_next       = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        div_req.divisor = DIV_W'(rate_div);
        if (div_rsp.done) begin
          if (step_counter == STEP_W'(1)) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      core_clock <= CLOCK_RESET;
    end else if (cfg_wr_en) begin
      core_clock <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_counter  <= '0;
      best_fraction <= FRAC_DEFAULT;
      best_step     <= STEP_DEFAULT;
      best_prescale <= PRESCALE_DEFAULT;
      err           <= 1'b0;
    end else begin
      if (in_fire) begin
        rate_hz       <= requested_rate_hz;
        step_counter  <= '0;
        best_fraction <= FRAC_DEFAULT;
        best_step     <= STEP_DEFAULT;
        best_prescale <= PRESCALE_DEFAULT;
        err           <= 1'b0;
      end
      if (state == ST_DIV_CLK && div_rsp.done) begin
        clk_div <= div_rsp.quotient[CLK_DIV_W-1:0];
      end
      if (state == ST_DIV_RATE && div_rsp.done) begin
        rate_div <= div_rsp.quotient[RATE_DIV_W-1:0];
        if (div_rsp.quotient == '0) begin
          err <= 1'b1;
        end else begin
          step_counter <= STEP_MAX;
        end
      end
      if (state == ST_DIV_STEP && div_rsp.done) begin
        if (better) begin
          best_fraction <= FIELD_W'(frac);
          best_prescale <= whole[FIELD_W-1:0];
          best_step     <= FIELD_W'(step_counter);
        end
        step_counter <= step_counter - 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      divider_step <= best_step;
      prescale_int <= best_prescale;
      frac_residue <= best_fraction;
      rate_error   <= err;
    end
  end

endmodule

`default_nettype wire
